// File: rtl/core/hcp_pkg.sv
// Shared types, register map and sigmoid tables of the hole cost unit.
`timescale 1ns / 1ps

package hcp_pkg;

  localparam int APB_AW      = 5;
  localparam int RATIO_STEPS = 256;
  localparam int K_W         = 9;

  localparam logic [2:0] REG_NEG_THR = 3'd0;
  localparam logic [2:0] REG_SIGMA   = 3'd1;
  localparam logic [2:0] REG_RISE    = 3'd2;
  localparam logic [2:0] REG_FALL    = 3'd3;
  localparam logic [2:0] REG_UNSEEN  = 3'd4;

  localparam logic [14:0] RST_NEG_THR = 15'd150;
  localparam logic [14:0] RST_SIGMA   = 15'd50;
  localparam logic [16:0] RST_RISE    = 17'd13107;
  localparam logic [16:0] RST_FALL    = 17'd6554;
  localparam logic [16:0] RST_UNSEEN  = 17'd3277;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [63:0] EXP_STEP    = 64'd4034748382;

  typedef struct packed {
    logic [14:0] neg_thr;
    logic [14:0] sigma;
    logic [16:0] rise;
    logic [16:0] fall;
    logic [16:0] unseen;
  } hcp_cfg_t;

  typedef struct packed {
    logic [15:0]        cell_id;
    logic signed [15:0] resid;
    logic [16:0]        pers;
  } hcp_item_t;

  typedef struct packed {
    logic [15:0]        cell_id;
    logic [16:0]        cost;
    logic signed [15:0] resid;
    logic [16:0]        pers;
  } hcp_res_t;

  typedef logic [RATIO_STEPS:0][16:0] sig_tab_t;

  // restoring division, used only while the tables are built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sig_tab_t sig_table(input logic neg);
    logic [63:0] t;
    logic [63:0] den;
    sig_tab_t    tab;
    t = 64'd1 << 32;
    for (int k = 0; k <= RATIO_STEPS; k++) begin
      den = (64'd1 << 32) + t;
      if (neg) begin
        tab[k] = 17'(udiv64((64'd1 << 48) + (den >> 1), den));
      end else begin
        tab[k] = 17'(udiv64((t << 16) + (den >> 1), den));
      end
      t = (t * EXP_STEP + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_POS = sig_table(1'b0);
  localparam sig_tab_t SIG_NEG = sig_table(1'b1);

endpackage

// File: rtl/core/hcp_if.sv
// Valid/ready channel interfaces for cell words and result words.
`timescale 1ns / 1ps

interface hcp_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        cell_index;
  logic [15:0]        point_count;
  logic signed [15:0] lowest_height_mm;
  logic signed [15:0] ground_height_mm;

  modport source (output valid, cell_index, point_count, lowest_height_mm,
                  ground_height_mm, input ready);
  modport sink (input valid, cell_index, point_count, lowest_height_mm,
                ground_height_mm, output ready);
endinterface

interface hcp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_cell_index;
  logic [16:0]        cost_q16;
  logic signed [15:0] stored_residual_mm;
  logic [16:0]        stored_persistence;

  modport source (output valid, out_cell_index, cost_q16, stored_residual_mm,
                  stored_persistence, input ready);
  modport sink (input valid, out_cell_index, cost_q16, stored_residual_mm,
                stored_persistence, output ready);
endinterface

// File: rtl/core/hole_cost_persistence_update_unit.sv
// Top level: APB registers, cell state pipeline, cost pipeline, output skid.
`timescale 1ns / 1ps

// One map cell word is taken per clock while the output skid word is empty,
// and result words leave in order; a run of words for the same cell back to
// back is handled by forwarding the last state write past the state RAM. The
// rate is set by the single read and write port of the per-cell state RAM,
// which is read once and written once per word. After reset a clearing pass
// zeroes all MAP_CELLS state RAM entries (65536 by default) at one entry per
// cycle, during which in_i.ready stays low; register writes are taken
// meanwhile. The output skid word makes in_i.ready depend on registers only.
module hole_cost_persistence_update_unit #(
  parameter int MAP_CELLS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hcp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  hcp_in_if.sink                     in_i,
  hcp_out_if.source                  res_o
);
  import hcp_pkg::*;

  hcp_cfg_t  cfg;
  logic      en;
  logic      b_v, m_v;
  hcp_item_t b_item;
  hcp_res_t  m_res;

  logic      ov_q, sv_q;
  hcp_res_t  od_q, sd_q;

  assign pready = 1'b1;
  assign en     = !sv_q;

  hcp_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  hcp_state #(
    .MAP_CELLS (MAP_CELLS)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .b_v_o    (b_v),
    .b_item_o (b_item)
  );

  hcp_cost u_cost (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg),
    .b_v_i    (b_v),
    .b_item_i (b_item),
    .m_v_o    (m_v),
    .m_res_o  (m_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (en) begin
      if (ov_q && !res_o.ready) begin
        sv_q <= m_v;
      end else begin
        ov_q <= m_v;
      end
    end else if (res_o.ready) begin
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ov_q && !res_o.ready) begin
        sd_q <= m_res;
      end else begin
        od_q <= m_res;
      end
    end else if (res_o.ready) begin
      od_q <= sd_q;
    end
  end

  assign res_o.valid              = ov_q;
  assign res_o.out_cell_index     = od_q.cell_id;
  assign res_o.cost_q16           = od_q.cost;
  assign res_o.stored_residual_mm = od_q.resid;
  assign res_o.stored_persistence = od_q.pers;

endmodule

// File: rtl/core/hcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hcp_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hcp_cfg.sv
// APB register block for thresholds, sigmoid width and persistence steps.
`timescale 1ns / 1ps

module hcp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [hcp_pkg::APB_AW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output hcp_pkg::hcp_cfg_t           cfg_o
);
  import hcp_pkg::*;

  hcp_cfg_t   cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr_i[APB_AW-1:2];
  assign wr  = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neg_thr <= RST_NEG_THR;
      cfg_q.sigma   <= RST_SIGMA;
      cfg_q.rise    <= RST_RISE;
      cfg_q.fall    <= RST_FALL;
      cfg_q.unseen  <= RST_UNSEEN;
    end else if (wr) begin
      unique case (idx)
        REG_NEG_THR: cfg_q.neg_thr <= pwdata_i[14:0];
        REG_SIGMA:   cfg_q.sigma   <= pwdata_i[14:0];
        REG_RISE:    cfg_q.rise    <= pwdata_i[16:0];
        REG_FALL:    cfg_q.fall    <= pwdata_i[16:0];
        REG_UNSEEN:  cfg_q.unseen  <= pwdata_i[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NEG_THR: prdata_o = 32'(cfg_q.neg_thr);
      REG_SIGMA:   prdata_o = 32'(cfg_q.sigma);
      REG_RISE:    prdata_o = 32'(cfg_q.rise);
      REG_FALL:    prdata_o = 32'(cfg_q.fall);
      REG_UNSEEN:  prdata_o = 32'(cfg_q.unseen);
      default:     prdata_o = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/hcp_state.sv
// Cell fold, per-cell state read-modify-write with forwarding, clearing pass.
`timescale 1ns / 1ps

module hcp_state #(
  parameter int MAP_CELLS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  hcp_pkg::hcp_cfg_t  cfg_i,
  hcp_in_if.sink             in_i,
  output logic               b_v_o,
  output hcp_pkg::hcp_item_t b_item_o
);
  import hcp_pkg::*;

  localparam int AW = $clog2(MAP_CELLS);
  localparam int DW = 33;

  typedef struct packed {
    logic [15:0]        cell_id;
    logic               obs;
    logic               hole;
    logic signed [15:0] resid;
  } req_t;

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          accept;

  logic signed [16:0] diff;
  logic signed [15:0] resid_sat;
  logic signed [17:0] hsum;
  req_t               req_d;

  logic          f1_v_q, f2_v_q, a_v_q, b_v_q;
  req_t          f1_q, f2_q, a_q;
  logic [AW-1:0] f2_slot_d, f2_slot_q, a_slot_q;
  hcp_item_t     b_q, a_new;

  logic          fwd_v_q;
  logic [AW-1:0] fwd_slot_q;
  logic [DW-1:0] fwd_data_q;
  logic [DW-1:0] ram_rdata, old_data;
  logic [16:0]   old_pers;
  logic [15:0]   old_resid;
  logic [17:0]   pers_add;
  logic [16:0]   pers_rise, pers_fall, pers_unseen;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          a_wr;

  assign in_i.ready = en_i && !clr_busy_q;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AW'(MAP_CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_comb begin
    diff = 17'(in_i.lowest_height_mm) - 17'(in_i.ground_height_mm);
    if (diff[16] != diff[15]) begin
      resid_sat = diff[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      resid_sat = diff[15:0];
    end
    hsum          = {{2{resid_sat[15]}}, resid_sat} + {3'b000, cfg_i.neg_thr};
    req_d.cell_id = in_i.cell_index;
    req_d.obs     = (in_i.point_count != 16'd0);
    req_d.hole    = hsum[17] || (hsum == 18'sd0);
    req_d.resid   = resid_sat;
  end

  generate
    if (MAP_CELLS < 65536) begin : g_fold
      localparam logic [32:0] FOLD_MUL =
        33'(((64'd1 << 32) + 64'(MAP_CELLS) - 64'd1) / 64'(MAP_CELLS));
      logic [15:0] quo_q;
      logic [48:0] prod;
      logic [31:0] back;

      assign prod = 49'(req_d.cell_id) * 49'(FOLD_MUL);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q <= prod[47:32];
        end
      end

      assign back      = 32'(quo_q) * 32'(MAP_CELLS);
      assign f2_slot_d = AW'(f1_q.cell_id - back[15:0]);
    end else begin : g_nofold
      assign f2_slot_d = AW'(f1_q.cell_id);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
    end else if (en_i) begin
      f1_v_q <= accept;
      f2_v_q <= f1_v_q;
      a_v_q  <= f2_v_q;
      b_v_q  <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q      <= req_d;
      f2_q      <= f1_q;
      f2_slot_q <= f2_slot_d;
      a_q       <= f2_q;
      a_slot_q  <= f2_slot_q;
      b_q       <= a_new;
    end
  end

  hcp_ram #(
    .WIDTH (DW),
    .DEPTH (MAP_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en_i && f2_v_q),
    .raddr_i (f2_slot_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    old_data  = (fwd_v_q && fwd_slot_q == a_slot_q) ? fwd_data_q : ram_rdata;
    old_resid = old_data[DW-1:17];
    old_pers  = old_data[16:0];

    pers_add    = {1'b0, old_pers} + {1'b0, cfg_i.rise};
    pers_rise   = (pers_add > 18'(ONE_Q16)) ? ONE_Q16 : pers_add[16:0];
    pers_fall   = (old_pers > cfg_i.fall) ? old_pers - cfg_i.fall : 17'd0;
    pers_unseen = (old_pers > cfg_i.unseen) ? old_pers - cfg_i.unseen : 17'd0;

    a_new.cell_id = a_q.cell_id;
    if (a_q.obs) begin
      a_new.resid = a_q.resid;
      a_new.pers  = a_q.hole ? pers_rise : pers_fall;
    end else begin
      a_new.resid = old_resid;
      a_new.pers  = pers_unseen;
    end
  end

  assign a_wr      = en_i && a_v_q;
  assign ram_we    = clr_busy_q || a_wr;
  assign ram_waddr = clr_busy_q ? clr_addr_q : a_slot_q;
  assign ram_wdata = clr_busy_q ? '0 : {a_new.resid, a_new.pers};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (a_wr) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      fwd_slot_q <= a_slot_q;
      fwd_data_q <= {a_new.resid, a_new.pers};
    end
  end

  assign b_v_o    = b_v_q;
  assign b_item_o = b_q;

endmodule

// File: rtl/core/hcp_cost.sv
// Ratio divider pipeline, sigmoid table lookup and persistence product.
`timescale 1ns / 1ps

module hcp_cost (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  hcp_pkg::hcp_cfg_t  cfg_i,
  input  logic               b_v_i,
  input  hcp_pkg::hcp_item_t b_item_i,
  output logic               m_v_o,
  output hcp_pkg::hcp_res_t  m_res_o
);
  import hcp_pkg::*;

  localparam int DS = 5;

  logic [14:0] sig_eff;
  logic [23:0] sig24;
  logic [15:0] mag;
  logic [23:0] num;

  logic           dv_q   [DS];
  hcp_item_t      dit_q  [DS];
  logic [23:0]    drem_q [DS];
  logic [K_W-1:0] dquo_q [DS];
  logic           dovf_q [DS];
  logic [23:0]    drem_d [DS];
  logic [K_W-1:0] dquo_d [DS];
  logic           dovf0;

  logic           l_v_q, m_v_q;
  hcp_item_t      l_it_q;
  logic [16:0]    l_sig_q;
  logic [K_W-1:0] k_sel;
  logic [16:0]    sig_d;
  logic [33:0]    prod;
  hcp_res_t       m_res_q;

  assign sig_eff = (cfg_i.sigma == 15'd0) ? 15'd1 : cfg_i.sigma;
  assign sig24   = 24'(sig_eff);

  always_comb begin
    logic [23:0] rem;
    logic [K_W-1:0] quo;
    int b;
    mag   = b_item_i.resid[15] ? 16'(-b_item_i.resid) : 16'(b_item_i.resid);
    num   = {4'd0, mag, 4'd0} + 24'(sig_eff[14:1]);
    dovf0 = num >= (sig24 << 9);
    if (num >= (sig24 << 8)) begin
      drem_d[0] = num - (sig24 << 8);
      dquo_d[0] = 9'h100;
    end else begin
      drem_d[0] = num;
      dquo_d[0] = 9'h000;
    end
    for (int s = 1; s < DS; s++) begin
      rem = drem_q[s-1];
      quo = dquo_q[s-1];
      for (int j = 0; j < 2; j++) begin
        b = 2 * (DS - 1 - s) + 1 - j;
        if (rem >= (sig24 << b)) begin
          rem    = rem - (sig24 << b);
          quo[b] = 1'b1;
        end
      end
      drem_d[s] = rem;
      dquo_d[s] = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DS; s++) begin
        dv_q[s] <= 1'b0;
      end
      l_v_q <= 1'b0;
      m_v_q <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= b_v_i;
      for (int s = 1; s < DS; s++) begin
        dv_q[s] <= dv_q[s-1];
      end
      l_v_q <= dv_q[DS-1];
      m_v_q <= l_v_q;
    end
  end

  always_comb begin
    if (dovf_q[DS-1] || dquo_q[DS-1] > K_W'(RATIO_STEPS)) begin
      k_sel = K_W'(RATIO_STEPS);
    end else begin
      k_sel = dquo_q[DS-1];
    end
    sig_d = dit_q[DS-1].resid[15] ? SIG_NEG[k_sel] : SIG_POS[k_sel];
    prod  = 34'(l_it_q.pers) * 34'(l_sig_q) + 34'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dit_q[0]  <= b_item_i;
      drem_q[0] <= drem_d[0];
      dquo_q[0] <= dquo_d[0];
      dovf_q[0] <= dovf0;
      for (int s = 1; s < DS; s++) begin
        dit_q[s]  <= dit_q[s-1];
        drem_q[s] <= drem_d[s];
        dquo_q[s] <= dquo_d[s];
        dovf_q[s] <= dovf_q[s-1];
      end
      l_it_q          <= dit_q[DS-1];
      l_sig_q         <= sig_d;
      m_res_q.cell_id <= l_it_q.cell_id;
      m_res_q.resid   <= l_it_q.resid;
      m_res_q.pers    <= l_it_q.pers;
      m_res_q.cost    <= prod[32:16];
    end
  end

  assign m_v_o   = m_v_q;
  assign m_res_o = m_res_q;

endmodule
